@@ rtl/q16n_pkg.sv @@
`timescale 1ns / 1ps

package q16n_pkg;

    // word width of weights, activations, bias and the accumulator
    localparam int unsigned DATA_W = 32;
    // fractional bits of the q16 format
    localparam int unsigned Q_SHIFT = 16;
    // full signed product width
    localparam int unsigned PROD_W = 2 * DATA_W;

    // position flags that travel with an element down the pipeline
    typedef struct packed {
        logic first;
        logic last;
    } elem_tag_t;

endpackage

@@ rtl/q16n_mult.sv @@
`timescale 1ns / 1ps

module q16n_mult (
    input  logic                             aclk,
    input  logic                             load,
    input  logic [q16n_pkg::DATA_W-1:0]      weight,
    input  logic [q16n_pkg::DATA_W-1:0]      activation,
    output logic [q16n_pkg::DATA_W-1:0]      term
);

    logic signed [q16n_pkg::PROD_W-1:0] prod;
    logic [q16n_pkg::DATA_W-1:0]        term_reg;
    logic [q16n_pkg::DATA_W-1:0]        term_next;

    // signed 32x32 product, scaled back to q16 and cut to one word
    assign prod      = $signed(weight) * $signed(activation);
    assign term_next = prod[q16n_pkg::Q_SHIFT +: q16n_pkg::DATA_W];

    always_ff @(posedge aclk) begin
        if (load) begin
            term_reg <= term_next;
        end
    end

    assign term = term_reg;

endmodule

@@ rtl/q16_neuron_dot_product_relu.sv @@
`timescale 1ns / 1ps
// a last element accepted at one edge passes the input register, then the product register
// and then the result register before it shows on m_tvalid; a waiting result can hold it back
// throughput: one element per cycle, set by the registered multiplier and the
// one-add accumulator loop; a waiting result holds back only a last element that has
// reached the accumulator, and everything queued behind it
// reset: aresetn synchronous active low; clears all valid flags and the accumulator,
// and sets relu_enable to 1

module q16_neuron_dot_product_relu (
    input  logic        aclk,
    input  logic        aresetn,

    // configuration: relu_enable
    input  logic        cfg_we,
    input  logic        cfg_wdata,

    // element requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [95:0] s_tdata,   // weight [31:0], activation [63:32], bias [95:64]
    input  logic        s_tuser,   // first_element
    input  logic        s_tlast,   // last_element

    // neuron results
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // neuron_out [31:0]
);

    localparam int unsigned W = q16n_pkg::DATA_W;

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic relu_en_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            relu_en_reg <= 1'b1;
        end else if (cfg_we) begin
            relu_en_reg <= cfg_wdata;
        end
    end

    // ---------------------------------------------------------------
    // pipeline control
    // ---------------------------------------------------------------
    logic                in_valid_reg;
    logic                prod_valid_reg;
    logic                m_valid_reg;
    q16n_pkg::elem_tag_t in_tag_reg;
    q16n_pkg::elem_tag_t prod_tag_reg;

    logic out_free;
    logic prod_go;
    logic prod_ready;
    logic in_go;
    logic in_ready;
    logic s_fire;

    // result register can take a new result this cycle
    assign out_free   = !m_valid_reg || m_tready;
    // a non-last element only touches the accumulator, so it never waits on the output
    assign prod_go    = prod_valid_reg && (!prod_tag_reg.last || out_free);
    assign prod_ready = !prod_valid_reg || prod_go;
    assign in_go      = in_valid_reg && prod_ready;
    assign in_ready   = !in_valid_reg || prod_ready;
    assign s_tready   = in_ready;
    assign s_fire     = s_tvalid && in_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            prod_valid_reg <= 1'b0;
        end else begin
            if (in_ready) begin
                in_valid_reg <= s_tvalid;
            end
            if (prod_ready) begin
                prod_valid_reg <= in_valid_reg;
            end
        end
    end

    // ---------------------------------------------------------------
    // stage 1: input register
    // ---------------------------------------------------------------
    logic [W-1:0] in_weight_reg;
    logic [W-1:0] in_act_reg;
    logic [W-1:0] in_bias_reg;

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_weight_reg    <= s_tdata[0 +: W];
            in_act_reg       <= s_tdata[W +: W];
            in_bias_reg      <= s_tdata[2*W +: W];
            in_tag_reg.first <= s_tuser;
            in_tag_reg.last  <= s_tlast;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: q16 product register, bias and flags ride alongside
    // ---------------------------------------------------------------
    logic [W-1:0] term;
    logic [W-1:0] prod_bias_reg;

    q16n_mult u_mult (
        .aclk       (aclk),
        .load       (in_go),
        .weight     (in_weight_reg),
        .activation (in_act_reg),
        .term       (term)
    );

    always_ff @(posedge aclk) begin
        if (in_go) begin
            prod_bias_reg <= in_bias_reg;
            prod_tag_reg  <= in_tag_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: accumulate, relu and result register
    // ---------------------------------------------------------------
    logic [W-1:0] acc_reg;
    logic [W-1:0] acc_next;
    logic [W-1:0] sum;
    logic [W-1:0] m_data_reg;
    logic [W-1:0] m_data_next;
    logic         m_valid_next;

    // an opener restarts from its bias, anything else keeps adding (wraps mod 2^32)
    assign sum = (prod_tag_reg.first ? prod_bias_reg : acc_reg) + term;

    always_comb begin
        acc_next     = acc_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        if (prod_go) begin
            if (prod_tag_reg.last) begin
                // neuron closes: emit and start the next one from zero
                acc_next     = '0;
                m_data_next  = (relu_en_reg && sum[W-1]) ? '0 : sum;
                m_valid_next = 1'b1;
            end else begin
                acc_next = sum;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
